// ----- sv/csfw_pkg.sv -----
// ----------------------------------------------------------------------------
// csfw_pkg
// Shared types and constants of the counting semaphore with a waiter queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package csfw_pkg;

   localparam int CMD_W    = 2;
   localparam int TASK_W   = 8;
   localparam int STATUS_W = 3;
   localparam int TOKEN_W  = 16;
   localparam int LIMIT_W  = 5;
   localparam int CSR_IDX_W = 1;

   localparam int DEF_QUEUE_DEPTH = 16;
   localparam int DEF_MAX_COUNT   = 65535;

   localparam logic [LIMIT_W-1:0] RESET_WAIT_LIMIT = 5'd16;

   localparam logic [CSR_IDX_W-1:0] CSR_START_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WAIT_LIMIT  = 1'd1;

   typedef enum logic [CMD_W-1:0] {
      CMD_WAIT    = 2'd0,
      CMD_TRYWAIT = 2'd1,
      CMD_SIGNAL  = 2'd2,
      CMD_QUERY   = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_GRANTED  = 3'd0,
      STATUS_BLOCKED  = 3'd1,
      STATUS_REFUSED  = 3'd2,
      STATUS_COUNTED  = 3'd3,
      STATUS_HANDED   = 3'd4,
      STATUS_OVERFLOW = 3'd5,
      STATUS_QUERY    = 3'd6
   } status_type;

   typedef enum logic [0:0] {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      logic load_req;
      logic commit;
   } ctl_type;

endpackage

`default_nettype wire

// ----- sv/csfw_ctrl.sv -----
// ----------------------------------------------------------------------------
// csfw_ctrl
// Sequencer: takes a command, waits for the result register, then commits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csfw_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output csfw_pkg::ctl_type       ctl
);

   csfw_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= csfw_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_stall    = 1'b1;
      ctl.load_req = 1'b0;
      ctl.commit   = 1'b0;
      unique case (state_ff)
         csfw_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ctl.load_req = 1'b1;
               state_in     = csfw_pkg::ST_EXEC;
            end
         end
         csfw_pkg::ST_EXEC: begin
            if (out_free) begin
               ctl.commit = 1'b1;
               state_in   = csfw_pkg::ST_IDLE;
            end
         end
         default: state_in = csfw_pkg::ST_IDLE;
      endcase
      rsp_valid_in = ctl.commit || (rsp_valid_ff && rsp_stall);
   end

endmodule

`default_nettype wire

// ----- sv/csfw_datapath.sv -----
// ----------------------------------------------------------------------------
// csfw_datapath
// Token counter, waiter queue memory with pointers, and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csfw_datapath #(
   parameter int QUEUE_DEPTH = csfw_pkg::DEF_QUEUE_DEPTH,
   parameter int MAX_COUNT   = csfw_pkg::DEF_MAX_COUNT,
   localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1)
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire csfw_pkg::ctl_type                 ctl,
   input  wire logic [csfw_pkg::CMD_W-1:0]        req_command,
   input  wire logic [csfw_pkg::TASK_W-1:0]       req_task_id,
   input  wire logic                              csr_valid,
   input  wire logic [csfw_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [csfw_pkg::TOKEN_W-1:0]      csr_wdata,
   output logic [csfw_pkg::STATUS_W-1:0]          rsp_status,
   output logic                                   rsp_woken_valid,
   output logic [csfw_pkg::TASK_W-1:0]            rsp_woken_task,
   output logic [csfw_pkg::TOKEN_W-1:0]           rsp_tokens_now,
   output logic [FILL_W-1:0]                      rsp_waiters_now
);

   localparam int TOKEN_W = csfw_pkg::TOKEN_W;
   localparam int TASK_W  = csfw_pkg::TASK_W;
   localparam int LIMIT_W = csfw_pkg::LIMIT_W;
   localparam int SUM_W   = IDX_W + 1;
   localparam int CMP_W   = (FILL_W > LIMIT_W) ? FILL_W : LIMIT_W;
   localparam logic [TOKEN_W-1:0] COUNT_CAP =
      (MAX_COUNT < 65535) ? TOKEN_W'(MAX_COUNT) : {TOKEN_W{1'b1}};
   localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(QUEUE_DEPTH - 1);
   localparam logic [FILL_W-1:0] DEPTH_FILL = FILL_W'(QUEUE_DEPTH);
   localparam logic [SUM_W-1:0]  DEPTH_SUM  = SUM_W'(QUEUE_DEPTH);

   logic [TASK_W-1:0]     waiter_mem [QUEUE_DEPTH];
   logic [TASK_W-1:0]     rdata_ff;

   csfw_pkg::cmd_type     cmd_ff;
   logic [TASK_W-1:0]     task_ff;
   logic [TOKEN_W-1:0]    token_ff, token_in, tok_nx;
   logic [IDX_W-1:0]      head_ff, head_in, head_nx, tail;
   logic [FILL_W-1:0]     fill_ff, fill_in, fill_nx;
   logic [LIMIT_W-1:0]    limit_ff, limit_in;
   logic [SUM_W-1:0]      tail_sum;
   logic                  free_token, full, push, handed;
   csfw_pkg::status_type  st;
   logic [TOKEN_W-1:0]    load_value;

   logic [csfw_pkg::STATUS_W-1:0] status_ff;
   logic                          woken_valid_ff;
   logic [TASK_W-1:0]             woken_task_ff;
   logic [TOKEN_W-1:0]            tokens_now_ff;
   logic [FILL_W-1:0]             waiters_now_ff;

   assign free_token = (token_ff != '0) && (fill_ff == '0);
   assign full       = (CMP_W'(fill_ff) >= CMP_W'(limit_ff)) || (fill_ff >= DEPTH_FILL);
   assign tail_sum   = {1'b0, head_ff} + SUM_W'(fill_ff);
   assign tail       = (tail_sum >= DEPTH_SUM) ? IDX_W'(tail_sum - DEPTH_SUM)
                                               : IDX_W'(tail_sum);
   assign load_value = (csr_wdata > COUNT_CAP) ? COUNT_CAP : csr_wdata;

   always_comb begin
      tok_nx  = token_ff;
      fill_nx = fill_ff;
      head_nx = head_ff;
      push    = 1'b0;
      handed  = 1'b0;
      st      = csfw_pkg::STATUS_QUERY;
      unique case (cmd_ff)
         csfw_pkg::CMD_WAIT: begin
            if (free_token) begin
               tok_nx = token_ff - TOKEN_W'(1);
               st     = csfw_pkg::STATUS_GRANTED;
            end else if (full) begin
               st = csfw_pkg::STATUS_OVERFLOW;
            end else begin
               push    = 1'b1;
               fill_nx = fill_ff + FILL_W'(1);
               st      = csfw_pkg::STATUS_BLOCKED;
            end
         end
         csfw_pkg::CMD_TRYWAIT: begin
            if (free_token) begin
               tok_nx = token_ff - TOKEN_W'(1);
               st     = csfw_pkg::STATUS_GRANTED;
            end else begin
               st = csfw_pkg::STATUS_REFUSED;
            end
         end
         csfw_pkg::CMD_SIGNAL: begin
            if (fill_ff != '0) begin
               handed  = 1'b1;
               head_nx = (head_ff == LAST_IDX) ? '0 : head_ff + IDX_W'(1);
               fill_nx = fill_ff - FILL_W'(1);
               st      = csfw_pkg::STATUS_HANDED;
            end else begin
               if (token_ff < COUNT_CAP) begin
                  tok_nx = token_ff + TOKEN_W'(1);
               end
               st = csfw_pkg::STATUS_COUNTED;
            end
         end
         csfw_pkg::CMD_QUERY: begin
            st = csfw_pkg::STATUS_QUERY;
         end
         default: st = csfw_pkg::STATUS_QUERY;
      endcase
   end

   always_comb begin
      token_in = ctl.commit ? tok_nx  : token_ff;
      fill_in  = ctl.commit ? fill_nx : fill_ff;
      head_in  = ctl.commit ? head_nx : head_ff;
      limit_in = limit_ff;
      if (csr_valid) begin
         priority if (csr_index == csfw_pkg::CSR_START_COUNT) begin
            token_in = load_value;
         end else if (csr_index == csfw_pkg::CSR_WAIT_LIMIT) begin
            limit_in = csr_wdata[LIMIT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff <= '0;
         fill_ff  <= '0;
         head_ff  <= '0;
         limit_ff <= csfw_pkg::RESET_WAIT_LIMIT;
      end else begin
         token_ff <= token_in;
         fill_ff  <= fill_in;
         head_ff  <= head_in;
         limit_ff <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_req) begin
         cmd_ff  <= csfw_pkg::cmd_type'(req_command);
         task_ff <= req_task_id;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.commit && push) begin
         waiter_mem[tail] <= task_ff;
      end
      rdata_ff <= waiter_mem[head_ff];
   end

   always_ff @(posedge clock) begin
      if (ctl.commit) begin
         status_ff      <= st;
         woken_valid_ff <= handed;
         woken_task_ff  <= handed ? rdata_ff : '0;
         tokens_now_ff  <= tok_nx;
         waiters_now_ff <= fill_nx;
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_woken_valid = woken_valid_ff;
   assign rsp_woken_task  = woken_task_ff;
   assign rsp_tokens_now  = tokens_now_ff;
   assign rsp_waiters_now = waiters_now_ff;

endmodule

`default_nettype wire

// ----- sv/counting_semaphore_fifo_waiters.sv -----
// ----------------------------------------------------------------------------
// counting_semaphore_fifo_waiters
// Counting semaphore whose blocked tasks wait in a first-in first-out queue.
// ----------------------------------------------------------------------------
//  Channel | Ports                                   | Direction
//  --------+-----------------------------------------+----------
//  req     | req_valid, req_stall, command, task_id  | in
//  rsp     | rsp_valid, rsp_stall, status .. waiters | out
//  csr     | csr_valid, csr_ready, index, wdata      | in
//
// Each command goes through two steps: capture, which registers it and reads the
// queue head from the waiter memory, and commit. The memory read is registered.
// A new command is taken while the previous result still waits for transfer;
// that command then holds the input stalled until the result register is free.
// Reset loads the count with zero, empties the queue and sets the queue limit to 16.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module counting_semaphore_fifo_waiters #(
   parameter int QUEUE_DEPTH = csfw_pkg::DEF_QUEUE_DEPTH,
   parameter int MAX_COUNT   = csfw_pkg::DEF_MAX_COUNT,
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1)
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [csfw_pkg::CMD_W-1:0]        req_command,
   input  wire logic [csfw_pkg::TASK_W-1:0]       req_task_id,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [csfw_pkg::STATUS_W-1:0]          rsp_status,
   output logic                                   rsp_woken_valid,
   output logic [csfw_pkg::TASK_W-1:0]            rsp_woken_task,
   output logic [csfw_pkg::TOKEN_W-1:0]           rsp_tokens_now,
   output logic [FILL_W-1:0]                      rsp_waiters_now,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [csfw_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [csfw_pkg::TOKEN_W-1:0]      csr_wdata
);

   csfw_pkg::ctl_type ctl;

   assign csr_ready = 1'b1;

   csfw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctl       (ctl)
   );

   csfw_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .MAX_COUNT   (MAX_COUNT)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .req_command     (req_command),
      .req_task_id     (req_task_id),
      .csr_valid       (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_status      (rsp_status),
      .rsp_woken_valid (rsp_woken_valid),
      .rsp_woken_task  (rsp_woken_task),
      .rsp_tokens_now  (rsp_tokens_now),
      .rsp_waiters_now (rsp_waiters_now)
   );

endmodule

`default_nettype wire

// ----- sv/csfw_checker.sv -----
// ----------------------------------------------------------------------------
// csfw_checker
// Port-level checks on the semaphore, attached to the top level by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csfw_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_stall,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_stall,
   input wire logic [csfw_pkg::STATUS_W-1:0]     rsp_status,
   input wire logic                              rsp_woken_valid,
   input wire logic [csfw_pkg::TASK_W-1:0]       rsp_woken_task
);

   // A task is released exactly when a signal hands the token over.
   a_woken_matches_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_woken_valid == (rsp_status == csfw_pkg::STATUS_HANDED)))
      else $error("woken_valid disagrees with status");

   a_woken_task_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_woken_valid) |-> (rsp_woken_task == '0))
      else $error("woken_task not zero without a release");

   // One command is in progress at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second command taken while one is in progress");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_status)))
      else $error("stalled result changed");

endmodule

bind counting_semaphore_fifo_waiters csfw_checker u_csfw_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_woken_valid (rsp_woken_valid),
   .rsp_woken_task  (rsp_woken_task)
);

`default_nettype wire
